>>> hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and keyword tables for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int KEYWORD_MAX_CHARS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_NUM       = 4'd1,
        M_NUMDOT    = 4'd2,
        M_FRAC      = 4'd3,
        M_WORD      = 4'd4,
        M_STR       = 4'd5,
        M_STRESC    = 4'd6,
        M_OP        = 4'd7,
        M_LINECMT   = 4'd8,
        M_BLOCK     = 4'd9,
        M_BLOCKSTAR = 4'd10
    } scan_mode_t;

    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_INT     = 6'd13;
    localparam logic [5:0] K_FLOAT   = 6'd14;
    localparam logic [5:0] K_STRING  = 6'd15;
    localparam logic [5:0] K_PLUS    = 6'd16;
    localparam logic [5:0] K_MINUS   = 6'd17;
    localparam logic [5:0] K_STAR    = 6'd18;
    localparam logic [5:0] K_DIV     = 6'd19;
    localparam logic [5:0] K_MOD     = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_EQ      = 6'd22;
    localparam logic [5:0] K_NE      = 6'd23;
    localparam logic [5:0] K_LT      = 6'd24;
    localparam logic [5:0] K_LE      = 6'd25;
    localparam logic [5:0] K_GT      = 6'd26;
    localparam logic [5:0] K_GE      = 6'd27;
    localparam logic [5:0] K_AND     = 6'd28;
    localparam logic [5:0] K_OR      = 6'd29;
    localparam logic [5:0] K_NOT     = 6'd30;
    localparam logic [5:0] K_LPAREN  = 6'd31;
    localparam logic [5:0] K_RPAREN  = 6'd32;
    localparam logic [5:0] K_LBRACE  = 6'd33;
    localparam logic [5:0] K_RBRACE  = 6'd34;
    localparam logic [5:0] K_LBRACK  = 6'd35;
    localparam logic [5:0] K_RBRACK  = 6'd36;
    localparam logic [5:0] K_SEMI    = 6'd37;
    localparam logic [5:0] K_COMMA   = 6'd38;
    localparam logic [5:0] K_COLON   = 6'd39;
    localparam logic [5:0] K_DOT     = 6'd40;
    localparam logic [5:0] K_STRCHAR = 6'd41;
    localparam logic [5:0] K_ERROR   = 6'd42;
    localparam logic [5:0] K_EOF     = 6'd43;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNTERM   = 3'd1;
    localparam logic [2:0] E_AMP      = 3'd2;
    localparam logic [2:0] E_BAR      = 3'd3;
    localparam logic [2:0] E_UNKNOWN  = 3'd4;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_BANG = 3'd2;
    localparam logic [2:0] OP_LT   = 3'd3;
    localparam logic [2:0] OP_GT   = 3'd4;
    localparam logic [2:0] OP_AMP  = 3'd5;
    localparam logic [2:0] OP_BAR  = 3'd6;
    localparam logic [2:0] OP_SLASH = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] line_no;
        logic [15:0] column_no;
        logic [15:0] lexeme_length;
        logic [7:0]  char_value;
        logic [2:0]  error_code;
        logic        last;
    } out_item_t;

    // keyword text, first byte in the low bits
    localparam logic [63:0] KW_TEXT [12] = '{
        64'h0000_0000_0074_6E69, // int
        64'h0000_0074_616F_6C66, // float
        64'h0000_0000_6C6F_6F62, // bool
        64'h0000_676E_6972_7473, // string
        64'h0000_0000_0000_6669, // if
        64'h0000_0000_6573_6C65, // else
        64'h0000_0065_6C69_6877, // while
        64'h0000_0000_0072_6F66, // for
        64'h6E6F_6974_636E_7566, // function
        64'h0000_6E72_7574_6572, // return
        64'h0000_0000_6575_7274, // true
        64'h0000_0065_736C_6166  // false
    };
    localparam logic [3:0] KW_LEN [12] = '{
        4'd3, 4'd5, 4'd4, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd8, 4'd6, 4'd4, 4'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] a);
        return (a == MAX16) ? MAX16 : a + 16'd1;
    endfunction

endpackage

>>> hw/rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item carry one source byte (kind 0) or the end mark
//   (kind 1) per request. m_valid/m_ready/m_item carry one token, decoded
//   string character or error per request; last flags the final result that
//   a request caused. Each byte may cause zero to three results.
//   A byte is scanned in the cycle it is accepted; its results are registered
//   in the output queue, which presents them at m_item. Throughput is one byte
//   per cycle while s_ready is high; scan state feeds back combinationally.
//   A queue of QUEUE_DEPTH results takes the bursts; s_ready drops only when
//   fewer than three free slots remain, i.e. when the receiver stalls long
//   enough to fill it. Reset empties the queue and returns the scanner to
//   line 1, column 1. After the end of file result the scanner restarts at
//   reset values.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int KEYWORD_MAX_CHARS = stt_pkg::KEYWORD_MAX_CHARS_DEF,
    parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stt_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output stt_pkg::out_item_t m_item
);
    import stt_pkg::*;

    scan_mode_t   mode_reg, mode_next;
    logic [15:0]  line_reg, line_next;
    logic [15:0]  col_reg, col_next;
    logic [15:0]  scol_reg, scol_next;
    logic [15:0]  tlen_reg, tlen_next;
    logic [2:0]   pop_reg, pop_next;
    logic [63:0]  word_reg, word_next;

    out_item_t    res [3];
    logic [1:0]   n;
    logic         accept;

    assign accept = s_valid && s_ready;

    function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [15:0] len);
        logic [5:0] k;
        k = K_IDENT;
        if (len <= 16'(KEYWORD_MAX_CHARS)) begin
            for (int i = 0; i < 12; i++) begin
                if ((16'(KW_LEN[i]) == len) && (KW_TEXT[i] == w)) k = 6'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic out_item_t mk(input logic [5:0] k, input logic [15:0] l,
                                     input logic [15:0] c, input logic [15:0] len,
                                     input logic [7:0] chv, input logic [2:0] e);
        out_item_t r;
        r.token_kind = k; r.line_no = l; r.column_no = c; r.lexeme_length = len;
        r.char_value = chv; r.error_code = e; r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [7:0]  c;
        logic        to_idle;
        logic [2:0]  op;
        logic [5:0]  single;
        logic [15:0] col0, line_cur, col_cur;
        out_item_t   r [3];
        logic [1:0]  k;

        c = s_item.ch;
        to_idle = 1'b0;
        op = OP_NONE;
        single = '0;
        k = '0;
        col0 = col_reg;
        line_cur = line_reg;
        col_cur = col_reg;
        for (int i = 0; i < 3; i++) r[i] = mk('0, '0, '0, '0, '0, E_NONE);
        mode_next = mode_reg; line_next = line_reg; col_next = col_reg;
        scol_next = scol_reg; tlen_next = tlen_reg; pop_next = pop_reg;
        word_next = word_reg;

        if (s_item.kind) begin
            unique case (mode_reg)
                M_NUM: begin
                    r[k] = mk(K_INT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                end
                M_NUMDOT: begin
                    r[k] = mk(K_INT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                    r[k] = mk(K_DOT, line_reg, (col_reg == MAX16) ? MAX16 : col_reg - 16'd1,
                              16'd1, 8'd0, E_NONE); k++;
                end
                M_FRAC: begin
                    r[k] = mk(K_FLOAT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                end
                M_WORD: begin
                    r[k] = mk(word_kind(word_reg, tlen_reg), line_reg, scol_reg, tlen_reg,
                              8'd0, E_NONE);
                    k++;
                end
                M_STR, M_STRESC: begin
                    r[k] = mk(K_ERROR, line_reg, scol_reg, 16'd0, 8'd0, E_UNTERM); k++;
                end
                M_OP: begin
                    if (pop_reg == OP_AMP) begin
                        r[k] = mk(K_ERROR, line_reg, scol_reg, 16'd0, 8'd0, E_AMP); k++;
                    end else if (pop_reg == OP_BAR) begin
                        r[k] = mk(K_ERROR, line_reg, scol_reg, 16'd0, 8'd0, E_BAR); k++;
                    end else if (pop_reg != OP_NONE) begin
                        case (pop_reg)
                            OP_EQ:   single = K_ASSIGN;
                            OP_BANG: single = K_NOT;
                            OP_LT:   single = K_LT;
                            OP_GT:   single = K_GT;
                            default: single = K_DIV;
                        endcase
                        r[k] = mk(single, line_reg, scol_reg, 16'd1, 8'd0, E_NONE); k++;
                    end
                end
                default: ;
            endcase
            r[k] = mk(K_EOF, line_reg, col_reg, 16'd0, 8'd0, E_NONE); k++;
            mode_next = M_IDLE; line_next = 16'd1; col_next = 16'd1; scol_next = 16'd1;
            tlen_next = '0; pop_next = OP_NONE; word_next = '0;
        end else begin
            // advance position for this byte
            if (c == 8'h0A) begin
                line_cur = sat_inc(line_reg); col_cur = 16'd1;
            end else begin
                line_cur = line_reg; col_cur = sat_inc(col_reg);
            end
            unique case (mode_reg)
                M_NUM: begin
                    if (is_digit(c)) begin
                        line_next = line_cur; col_next = col_cur; tlen_next = sat_inc(tlen_reg);
                    end else if (c == 8'h2E) begin
                        line_next = line_cur; col_next = col_cur; mode_next = M_NUMDOT;
                    end else to_idle = 1'b1;
                end
                M_NUMDOT: begin
                    if (is_digit(c)) begin
                        line_next = line_cur; col_next = col_cur; mode_next = M_FRAC;
                        tlen_next = (tlen_reg >= 16'hFFFD) ? MAX16 : tlen_reg + 16'd2;
                    end else to_idle = 1'b1;
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        line_next = line_cur; col_next = col_cur; tlen_next = sat_inc(tlen_reg);
                    end else to_idle = 1'b1;
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        for (int j = 0; j < 8; j++) begin
                            if ((tlen_reg == 16'(j)) && (j < KEYWORD_MAX_CHARS))
                                word_next[8*j +: 8] = word_reg[8*j +: 8] | c;
                        end
                        line_next = line_cur; col_next = col_cur; tlen_next = sat_inc(tlen_reg);
                    end else to_idle = 1'b1;
                end
                M_STR: begin
                    line_next = line_cur; col_next = col_cur; tlen_next = sat_inc(tlen_reg);
                    if (c == 8'h22) begin
                        r[k] = mk(K_STRING, line_cur, scol_reg, sat_inc(tlen_reg), 8'd0,
                                  E_NONE);
                        k++;
                        mode_next = M_IDLE;
                    end else if (c == 8'h5C) begin
                        mode_next = M_STRESC;
                    end else begin
                        r[k] = mk(K_STRCHAR, line_cur, scol_reg, 16'd0, c, E_NONE); k++;
                    end
                end
                M_STRESC: begin
                    line_next = line_cur; col_next = col_cur; tlen_next = sat_inc(tlen_reg);
                    r[k] = mk(K_STRCHAR, line_cur, scol_reg, 16'd0,
                              (c == 8'h6E) ? 8'd10 : ((c == 8'h74) ? 8'd9 : c), E_NONE);
                    k++;
                    mode_next = M_STR;
                end
                M_OP: begin
                    if ((pop_reg == OP_SLASH) && ((c == 8'h2F) || (c == 8'h2A))) begin
                        line_next = line_cur; col_next = col_cur; pop_next = OP_NONE;
                        mode_next = (c == 8'h2F) ? M_LINECMT : M_BLOCKSTAR;
                    end else if (((pop_reg >= OP_EQ) && (pop_reg <= OP_GT) && (c == 8'h3D)) ||
                                 ((pop_reg == OP_AMP) && (c == 8'h26)) ||
                                 ((pop_reg == OP_BAR) && (c == 8'h7C))) begin
                        case (pop_reg)
                            OP_EQ:   single = K_EQ;
                            OP_BANG: single = K_NE;
                            OP_LT:   single = K_LE;
                            OP_GT:   single = K_GE;
                            OP_AMP:  single = K_AND;
                            default: single = K_OR;
                        endcase
                        line_next = line_cur; col_next = col_cur;
                        r[k] = mk(single, line_cur, scol_reg, 16'd2, 8'd0, E_NONE); k++;
                        mode_next = M_IDLE; pop_next = OP_NONE;
                    end else to_idle = 1'b1;
                end
                M_LINECMT: begin
                    line_next = line_cur; col_next = col_cur;
                    if (c == 8'h0A) mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    line_next = line_cur; col_next = col_cur;
                    if (c == 8'h2A) mode_next = M_BLOCKSTAR;
                end
                M_BLOCKSTAR: begin
                    line_next = line_cur; col_next = col_cur;
                    if (c == 8'h2F) mode_next = M_IDLE;
                    else if (c != 8'h2A) mode_next = M_BLOCK;
                end
                default: to_idle = 1'b1;
            endcase

            if (to_idle) begin
                // flush the pending token; position is still before this byte
                unique case (mode_reg)
                    M_NUM: begin
                        r[k] = mk(K_INT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                    end
                    M_NUMDOT: begin
                        r[k] = mk(K_INT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                        r[k] = mk(K_DOT, line_reg, (col_reg == MAX16) ? MAX16 : col_reg - 16'd1,
                                  16'd1, 8'd0, E_NONE); k++;
                    end
                    M_FRAC: begin
                        r[k] = mk(K_FLOAT, line_reg, scol_reg, tlen_reg, 8'd0, E_NONE); k++;
                    end
                    M_WORD: begin
                        r[k] = mk(word_kind(word_reg, tlen_reg), line_reg, scol_reg, tlen_reg,
                                  8'd0, E_NONE);
                        k++;
                    end
                    M_OP: begin
                        if (pop_reg == OP_AMP) begin
                            r[k] = mk(K_ERROR, line_reg, scol_reg, 16'd0, 8'd0, E_AMP); k++;
                        end else if (pop_reg == OP_BAR) begin
                            r[k] = mk(K_ERROR, line_reg, scol_reg, 16'd0, 8'd0, E_BAR); k++;
                        end else if (pop_reg != OP_NONE) begin
                            case (pop_reg)
                                OP_EQ:   single = K_ASSIGN;
                                OP_BANG: single = K_NOT;
                                OP_LT:   single = K_LT;
                                OP_GT:   single = K_GT;
                                default: single = K_DIV;
                            endcase
                            r[k] = mk(single, line_reg, scol_reg, 16'd1, 8'd0, E_NONE); k++;
                        end
                    end
                    default: ;
                endcase
                // scan this byte from idle
                col0 = col_reg;
                line_next = line_cur; col_next = col_cur;
                scol_next = col0; tlen_next = 16'd1;
                mode_next = M_IDLE; pop_next = OP_NONE;
                op = OP_NONE; single = '0;
                case (c)
                    8'h20, 8'h0D, 8'h09, 8'h0A: ;
                    8'h22: ;
                    8'h3D: op = OP_EQ;
                    8'h21: op = OP_BANG;
                    8'h3C: op = OP_LT;
                    8'h3E: op = OP_GT;
                    8'h26: op = OP_AMP;
                    8'h7C: op = OP_BAR;
                    8'h2F: op = OP_SLASH;
                    8'h2B: single = K_PLUS;
                    8'h2D: single = K_MINUS;
                    8'h2A: single = K_STAR;
                    8'h25: single = K_MOD;
                    8'h28: single = K_LPAREN;
                    8'h29: single = K_RPAREN;
                    8'h7B: single = K_LBRACE;
                    8'h7D: single = K_RBRACE;
                    8'h5B: single = K_LBRACK;
                    8'h5D: single = K_RBRACK;
                    8'h3B: single = K_SEMI;
                    8'h2C: single = K_COMMA;
                    8'h3A: single = K_COLON;
                    8'h2E: single = K_DOT;
                    default: ;
                endcase
                if ((c == 8'h20) || (c == 8'h0D) || (c == 8'h09) || (c == 8'h0A)) begin
                    tlen_next = '0;
                end else if (c == 8'h22) begin
                    mode_next = M_STR;
                end else if (op != OP_NONE) begin
                    mode_next = M_OP; pop_next = op;
                end else if (single != '0) begin
                    r[k] = mk(single, line_cur, col0, 16'd1, 8'd0, E_NONE); k++;
                end else if (is_digit(c)) begin
                    mode_next = M_NUM;
                end else if (is_alpha(c)) begin
                    mode_next = M_WORD; word_next = {56'd0, c};
                end else begin
                    r[k] = mk(K_ERROR, line_cur, col0, 16'd0, 8'd0, E_UNKNOWN); k++;
                end
            end
        end
        if (k != '0) r[k - 2'd1].last = 1'b1;
        res = r;
        n = k;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            line_reg <= 16'd1;
            col_reg  <= 16'd1;
            scol_reg <= 16'd1;
            tlen_reg <= '0;
            pop_reg  <= OP_NONE;
            word_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            scol_reg <= scol_next;
            tlen_reg <= tlen_next;
            pop_reg  <= pop_next;
            word_reg <= word_next;
        end
    end

    logic room;

    stt_out_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (accept ? n : 2'd0),
        .push_item  (res),
        .room       (room),
        .m_item     (m_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

    assign s_ready = room;

endmodule

>>> hw/rtl/stt_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_out_queue
// Result queue: takes up to three results in one cycle, drains one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module stt_out_queue #(
    parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_count,
    input  stt_pkg::out_item_t  push_item [3],
    output logic                room,
    output stt_pkg::out_item_t  m_item,
    output logic                m_valid,
    input  logic                m_ready
);
    import stt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    out_item_t           mem_reg [DEPTH];
    logic [AW-1:0]       wptr_reg, rptr_reg;
    logic [AW:0]         count_reg, count_next;
    logic                pop;

    assign m_valid = (count_reg != '0);
    assign m_item  = mem_reg[rptr_reg];
    assign pop     = m_valid && m_ready;
    // room for a full burst of three in this cycle
    assign room    = (count_reg <= (AW+1)'(DEPTH - 3));

    always_comb begin
        count_next = count_reg + (AW+1)'(push_count) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_reg + AW'(push_count);
            rptr_reg  <= rptr_reg + AW'(pop);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_count) begin
                mem_reg[wptr_reg + AW'(i)] <= push_item[i];
            end
        end
    end

endmodule

>>> dv/source_text_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// Drives source bytes and end marks into the tokenizer at random pacing and
// checks every token, string character and error against a scan model.
// ----------------------------------------------------------------------------
module source_text_tokenizer_test;
    import stt_pkg::*;

    localparam int KW_CHARS = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_item = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_item;

    source_text_tokenizer #(.KEYWORD_MAX_CHARS(KW_CHARS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    in_item_t  byte_queue[$];
    out_item_t token_queue[$];
    int        mismatches = 0;
    int        cycles = 0;

    // was the current request accepted at the last rising edge
    logic s_ready_seen = 1'b0;

    // scan state mirror
    scan_mode_t  mode = M_IDLE;
    logic [15:0] line_cnt = 16'd1, col_cnt = 16'd1, start_col = 16'd1, tok_len = 16'd0;
    logic [2:0]  pend_op = OP_NONE;
    logic [63:0] word_buf = '0;
    out_item_t   step_out[$];

    function automatic logic [15:0] add_sat(input logic [15:0] a, input int b);
        int s;
        s = a + b;
        return (s > 65535) ? MAX16 : s[15:0];
    endfunction

    function automatic void push_tok(input logic [5:0] k, input logic [15:0] ln,
                                     input logic [15:0] cl, input logic [15:0] len,
                                     input logic [7:0] cv, input logic [2:0] err);
        out_item_t r;
        r.token_kind = k; r.line_no = ln; r.column_no = cl;
        r.lexeme_length = len; r.char_value = cv; r.error_code = err; r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void advance_pos(input logic [7:0] c);
        if (c == 8'h0A) begin
            line_cnt = add_sat(line_cnt, 1);
            col_cnt = 16'd1;
        end else begin
            col_cnt = add_sat(col_cnt, 1);
        end
    endfunction

    function automatic logic [5:0] classify_word();
        if (tok_len > KW_CHARS) return K_IDENT;
        for (int i = 0; i < 12; i++) begin
            if (KW_TEXT[i] == word_buf && KW_LEN[i] == tok_len) return 6'(i + 1);
        end
        return K_IDENT;
    endfunction

    function automatic void close_pending();
        case (mode)
            M_NUM: push_tok(K_INT, line_cnt, start_col, tok_len, 8'd0, E_NONE);
            M_NUMDOT: begin
                push_tok(K_INT, line_cnt, start_col, tok_len, 8'd0, E_NONE);
                push_tok(K_DOT, line_cnt, (col_cnt == MAX16) ? MAX16 : col_cnt - 16'd1,
                         16'd1, 8'd0, E_NONE);
            end
            M_FRAC: push_tok(K_FLOAT, line_cnt, start_col, tok_len, 8'd0, E_NONE);
            M_WORD: push_tok(classify_word(), line_cnt, start_col, tok_len, 8'd0, E_NONE);
            M_STR, M_STRESC: push_tok(K_ERROR, line_cnt, start_col, 16'd0, 8'd0, E_UNTERM);
            M_OP: begin
                case (pend_op)
                    OP_AMP: push_tok(K_ERROR, line_cnt, start_col, 16'd0, 8'd0, E_AMP);
                    OP_BAR: push_tok(K_ERROR, line_cnt, start_col, 16'd0, 8'd0, E_BAR);
                    OP_EQ: push_tok(K_ASSIGN, line_cnt, start_col, 16'd1, 8'd0, E_NONE);
                    OP_BANG: push_tok(K_NOT, line_cnt, start_col, 16'd1, 8'd0, E_NONE);
                    OP_LT: push_tok(K_LT, line_cnt, start_col, 16'd1, 8'd0, E_NONE);
                    OP_GT: push_tok(K_GT, line_cnt, start_col, 16'd1, 8'd0, E_NONE);
                    OP_SLASH: push_tok(K_DIV, line_cnt, start_col, 16'd1, 8'd0, E_NONE);
                    default: ;
                endcase
            end
            default: ;
        endcase
        mode = M_IDLE;
        pend_op = OP_NONE;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        logic [15:0] col0;
        logic [5:0]  single;
        logic [2:0]  op;
        col0 = col_cnt;
        single = '0;
        op = OP_NONE;
        advance_pos(c);
        start_col = col0;
        tok_len = 16'd1;
        case (c)
            " ", 8'h0D, 8'h09, 8'h0A: begin
                tok_len = 16'd0;
                return;
            end
            "\"": begin
                mode = M_STR;
                return;
            end
            "=": op = OP_EQ;
            "!": op = OP_BANG;
            "<": op = OP_LT;
            ">": op = OP_GT;
            "&": op = OP_AMP;
            "|": op = OP_BAR;
            "/": op = OP_SLASH;
            "+": single = K_PLUS;
            "-": single = K_MINUS;
            "*": single = K_STAR;
            "%": single = K_MOD;
            "(": single = K_LPAREN;
            ")": single = K_RPAREN;
            "{": single = K_LBRACE;
            "}": single = K_RBRACE;
            "[": single = K_LBRACK;
            "]": single = K_RBRACK;
            ";": single = K_SEMI;
            ",": single = K_COMMA;
            ":": single = K_COLON;
            ".": single = K_DOT;
            default: ;
        endcase
        if (op != OP_NONE) begin
            mode = M_OP;
            pend_op = op;
        end else if (single != 0) begin
            push_tok(single, line_cnt, col0, 16'd1, 8'd0, E_NONE);
        end else if (is_digit(c)) begin
            mode = M_NUM;
        end else if (is_alpha(c)) begin
            mode = M_WORD;
            word_buf = {56'd0, c};
        end else begin
            push_tok(K_ERROR, line_cnt, col0, 16'd0, 8'd0, E_UNKNOWN);
        end
    endfunction

    function automatic void reset_scan();
        mode = M_IDLE; line_cnt = 16'd1; col_cnt = 16'd1; start_col = 16'd1;
        tok_len = 16'd0; pend_op = OP_NONE; word_buf = '0;
    endfunction

    // scan one request and queue the tokens it yields
    function automatic void predict_tokens(input in_item_t it);
        logic [7:0] c;
        bit rescan;
        c = it.ch;
        rescan = 1'b0;
        step_out.delete();
        if (it.kind) begin
            close_pending();
            push_tok(K_EOF, line_cnt, col_cnt, 16'd0, 8'd0, E_NONE);
            reset_scan();
        end else begin
            case (mode)
                M_NUM:
                    if (is_digit(c)) begin
                        advance_pos(c); tok_len = add_sat(tok_len, 1);
                    end else if (c == ".") begin
                        advance_pos(c); mode = M_NUMDOT;
                    end else rescan = 1'b1;
                M_NUMDOT:
                    if (is_digit(c)) begin
                        advance_pos(c); tok_len = add_sat(tok_len, 2); mode = M_FRAC;
                    end else rescan = 1'b1;
                M_FRAC:
                    if (is_digit(c)) begin
                        advance_pos(c); tok_len = add_sat(tok_len, 1);
                    end else rescan = 1'b1;
                M_WORD:
                    if (is_alpha(c) || is_digit(c)) begin
                        if (tok_len < KW_CHARS && tok_len < 16'd8)
                            word_buf[8*tok_len +: 8] = c;
                        advance_pos(c); tok_len = add_sat(tok_len, 1);
                    end else rescan = 1'b1;
                M_STR: begin
                    advance_pos(c); tok_len = add_sat(tok_len, 1);
                    if (c == "\"") begin
                        push_tok(K_STRING, line_cnt, start_col, tok_len, 8'd0, E_NONE);
                        mode = M_IDLE;
                    end else if (c == "\\") begin
                        mode = M_STRESC;
                    end else begin
                        push_tok(K_STRCHAR, line_cnt, start_col, 16'd0, c, E_NONE);
                    end
                end
                M_STRESC: begin
                    advance_pos(c); tok_len = add_sat(tok_len, 1);
                    push_tok(K_STRCHAR, line_cnt, start_col, 16'd0,
                             (c == "n") ? 8'd10 : ((c == "t") ? 8'd9 : c), E_NONE);
                    mode = M_STR;
                end
                M_OP:
                    if (pend_op == OP_SLASH && (c == "/" || c == "*")) begin
                        advance_pos(c);
                        mode = (c == "/") ? M_LINECMT : M_BLOCKSTAR;
                        pend_op = OP_NONE;
                    end else if ((pend_op inside {OP_EQ, OP_BANG, OP_LT, OP_GT} && c == "=")
                            || (pend_op == OP_AMP && c == "&")
                            || (pend_op == OP_BAR && c == "|")) begin
                        advance_pos(c);
                        case (pend_op)
                            OP_EQ: push_tok(K_EQ, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                            OP_BANG: push_tok(K_NE, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                            OP_LT: push_tok(K_LE, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                            OP_GT: push_tok(K_GE, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                            OP_AMP: push_tok(K_AND, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                            default: push_tok(K_OR, line_cnt, start_col, 16'd2, 8'd0, E_NONE);
                        endcase
                        mode = M_IDLE;
                        pend_op = OP_NONE;
                    end else rescan = 1'b1;
                M_LINECMT: begin
                    advance_pos(c);
                    if (c == 8'h0A) mode = M_IDLE;
                end
                M_BLOCK: begin
                    advance_pos(c);
                    if (c == "*") mode = M_BLOCKSTAR;
                end
                M_BLOCKSTAR: begin
                    advance_pos(c);
                    if (c == "/") mode = M_IDLE;
                    else if (c != "*") mode = M_BLOCK;
                end
                default: begin
                    mode = M_IDLE;
                    scan_fresh(c);
                end
            endcase
            if (rescan) begin
                close_pending();
                scan_fresh(c);
            end
        end
        if (step_out.size() > 0) step_out[$].last = 1'b1;
        foreach (step_out[i]) token_queue.insert(token_queue.size(), step_out[i]);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_queue.insert(byte_queue.size(), '{kind: 1'b0, ch: s[i]});
    endfunction

    function automatic void add_eof();
        byte_queue.insert(byte_queue.size(), '{kind: 1'b1, ch: 8'($urandom_range(0, 255))});
    endfunction

    // idle about a quarter of cycles, except in a quiet window
    function automatic bit take_gap();
        if (cycles >= 150 && cycles < 400) return 1'b0;
        return $urandom_range(0, 99) < 25;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (byte_queue.size() > 0 && !take_gap()) begin
                    s_item <= byte_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !take_gap();
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_tokens(s_item);
            end
            if (m_valid && m_ready) begin
                if (token_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected token %p", m_item);
                end else begin
                    out_item_t exp_tok;
                    exp_tok = token_queue.pop_front();
                    if (exp_tok !== m_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("token mismatch: expected %p got %p", exp_tok, m_item);
                    end
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    string pieces[] = '{"int", "float", "bool", "string", "if", "else", "while", "for",
        "function", "return", "true", "false", "functions", "x_1", "Abc", "42", "3.14",
        "7.", "==", "!=", "<=", ">=", "&&", "||", "=", "!", "<", ">", "&", "|", "/",
        "+", "-", "*", "%", "(", ")", "{", "}", "[", "]", ";", ",", ":", ".", " ",
        "\n", "\t", "\"a\\nb\\t\\\"c\"", "// note\n", "/* x */", "/*/", "\"hi\"", "@"};

    initial begin
        int sent;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // directed: keywords, operators, escapes, comment corners, errors
        add_text("int float bool string if else while for function return true false");
        add_eof();
        add_text("x1 functions 12 3.5 7.a == != <= >= && || = ! < > & | / ");
        add_eof();
        add_text("\"a\\n\\t\\q\" /*/ z // c\n/* a ** / */ @\377");
        add_eof();
        add_text("\"open\\"); add_eof();
        add_text("/* never"); add_eof();
        add_text("9."); add_eof();
        add_eof();
        // random: mostly token streams, some raw bytes
        sent = byte_queue.size();
        while (sent < 360) begin
            int n;
            n = $urandom_range(5, 30);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) < 8) begin
                    add_text(pieces[$urandom_range(0, pieces.size() - 1)]);
                    if ($urandom_range(0, 1)) add_text(" ");
                end else begin
                    byte_queue.insert(byte_queue.size(),
                                      '{kind: 1'b0, ch: 8'($urandom_range(0, 255))});
                end
            end
            if ($urandom_range(0, 3) != 0) add_eof();
            sent = byte_queue.size();
        end
        add_eof();
        wait (byte_queue.size() == 0 && !s_valid);
        wait (token_queue.size() == 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && token_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_out_queue.sv
hw/rtl/source_text_tokenizer.sv
dv/source_text_tokenizer_test.sv
